### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes, constants and state type for the saturating paint range query.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Request function codes.
    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;

    // Saturation limit of one color channel.
    localparam logic [7:0] CHAN_SAT = 8'd255;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RIGHT,
        ST_FINISH
    } state_t;

endpackage

### sv/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int EW    = 65
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [EW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [EW-1:0] rd_data
);

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/spq_sat.sv
// ----------------------------------------------------------------------------
// spq_sat
// Saturating difference of two prefix sums for one color channel.
// ----------------------------------------------------------------------------
module spq_sat #(
    parameter int PW = 18
) (
    input  logic [PW-1:0] hi,
    input  logic [PW-1:0] lo,
    output logic [7:0]    sum
);

    import spq_pkg::*;

    logic [PW-1:0] diff;

    // Clamp below at zero and above at the channel limit.
    always_comb
    begin
        diff = hi - lo;
        if (hi < lo)
        begin
            sum = '0;
        end
        else if (diff > PW'(CHAN_SAT))
        begin
            sum = CHAN_SAT;
        end
        else
        begin
            sum = diff[7:0];
        end
    end

endmodule

### sv/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: appends entries, walks the two dependent reads of a query and
// holds the result register.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int MAX_OPS = 1024,
    localparam int IDX_W  = $clog2(MAX_OPS + 1),
    localparam int AW     = $clog2(MAX_OPS),
    localparam int PW     = $clog2(MAX_OPS * 255 + 1),
    localparam int EW     = 3 * PW + IDX_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [1:0]       func,
    input  logic             kind,
    input  logic [7:0]       red_in,
    input  logic [7:0]       green_in,
    input  logic [7:0]       blue_in,
    input  logic [IDX_W-1:0] left_index,
    input  logic [IDX_W-1:0] right_index,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output logic [EW-1:0]    mem_wdata,
    output logic             mem_re,
    output logic [AW-1:0]    mem_raddr,
    input  logic [EW-1:0]    mem_rd_data
);

    import spq_pkg::*;

    localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_OPS);
    localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);

    // Control registers.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] op_count_reg, op_count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [PW-1:0]    tail_r_reg, tail_r_next;
    logic [PW-1:0]    tail_g_reg, tail_g_next;
    logic [PW-1:0]    tail_b_reg, tail_b_next;
    logic [IDX_W-1:0] tail_last_reg, tail_last_next;

    // Query working registers and result payload.
    logic [IDX_W-1:0] right_reg, right_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic [PW-1:0]    hi_r_reg, hi_r_next;
    logic [PW-1:0]    hi_g_reg, hi_g_next;
    logic [PW-1:0]    hi_b_reg, hi_b_next;
    logic             lo_zero_reg, lo_zero_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       blue_reg, blue_next;

    // Helper values.
    logic [IDX_W-1:0] count_inc;
    logic [PW-1:0]    new_r, new_g, new_b;
    logic [IDX_W-1:0] new_last;
    logic [IDX_W-1:0] right_sat, right_m1, left_adj, start0;
    logic [PW-1:0]    rd_r, rd_g, rd_b;
    logic [IDX_W-1:0] rd_last, set_start, start_max, start_m1;
    logic [PW-1:0]    lo_r, lo_g, lo_b;
    logic [7:0]       sat_r, sat_g, sat_b;

    // Unpack the read entry.
    assign rd_r    = mem_rd_data[EW-1 -: PW];
    assign rd_g    = mem_rd_data[EW-PW-1 -: PW];
    assign rd_b    = mem_rd_data[EW-2*PW-1 -: PW];
    assign rd_last = mem_rd_data[IDX_W-1:0];

    // Next entry for an append, built from the tail entry.
    assign count_inc = op_count_reg + ONE;
    assign new_r     = tail_r_reg + PW'(red_in);
    assign new_g     = tail_g_reg + PW'(green_in);
    assign new_b     = tail_b_reg + PW'(blue_in);
    assign new_last  = kind ? count_inc : tail_last_reg;

    // Query bounds at acceptance.
    assign right_sat = (right_index > op_count_reg) ? op_count_reg : right_index;
    assign right_m1  = right_sat - ONE;
    assign left_adj  = (left_index == '0) ? ONE : left_index;
    assign start0    = left_adj - ONE;

    // Start point once the last set operation is known.
    assign set_start = rd_last - ONE;
    assign start_max = (set_start > start_reg) ? set_start : start_reg;
    assign start_m1  = start_max - ONE;

    // Lower prefix comes from memory unless the range starts at entry zero.
    assign lo_r = lo_zero_reg ? '0 : rd_r;
    assign lo_g = lo_zero_reg ? '0 : rd_g;
    assign lo_b = lo_zero_reg ? '0 : rd_b;

    spq_sat #(.PW(PW)) u_sat_r (.hi(hi_r_reg), .lo(lo_r), .sum(sat_r));
    spq_sat #(.PW(PW)) u_sat_g (.hi(hi_g_reg), .lo(lo_g), .sum(sat_g));
    spq_sat #(.PW(PW)) u_sat_b (.hi(hi_b_reg), .lo(lo_b), .sum(sat_b));

    // Next state and memory control.
    always_comb
    begin
        state_next     = state_reg;
        op_count_next  = op_count_reg;
        rsp_valid_next = rsp_valid_reg;
        tail_r_next    = tail_r_reg;
        tail_g_next    = tail_g_reg;
        tail_b_next    = tail_b_reg;
        tail_last_next = tail_last_reg;
        right_next     = right_reg;
        start_next     = start_reg;
        hi_r_next      = hi_r_reg;
        hi_g_next      = hi_g_reg;
        hi_b_next      = hi_b_reg;
        lo_zero_next   = lo_zero_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        mem_we         = 1'b0;
        mem_waddr      = op_count_reg[AW-1:0];
        mem_wdata      = {new_r, new_g, new_b, new_last};
        mem_re         = 1'b0;
        mem_raddr      = right_m1[AW-1:0];

        // The result register empties on its transaction.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (func)
                        FN_CLEAR:
                        begin
                            op_count_next  = '0;
                            tail_r_next    = '0;
                            tail_g_next    = '0;
                            tail_b_next    = '0;
                            tail_last_next = ONE;
                        end
                        FN_APPEND:
                        begin
                            if (op_count_reg != MAX_CNT)
                            begin
                                mem_we         = 1'b1;
                                op_count_next  = count_inc;
                                tail_r_next    = new_r;
                                tail_g_next    = new_g;
                                tail_b_next    = new_b;
                                tail_last_next = new_last;
                            end
                        end
                        FN_QUERY:
                        begin
                            right_next = right_sat;
                            start_next = start0;
                            if (right_sat == '0)
                            begin
                                // Empty sequence: the result is zero.
                                hi_r_next    = '0;
                                hi_g_next    = '0;
                                hi_b_next    = '0;
                                lo_zero_next = 1'b1;
                                state_next   = ST_FINISH;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = right_m1[AW-1:0];
                                state_next = ST_RIGHT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RIGHT:
            begin
                state_next = ST_FINISH;
                if (start_max >= right_reg)
                begin
                    // Empty range after the last set operation.
                    hi_r_next    = '0;
                    hi_g_next    = '0;
                    hi_b_next    = '0;
                    lo_zero_next = 1'b1;
                end
                else
                begin
                    hi_r_next = rd_r;
                    hi_g_next = rd_g;
                    hi_b_next = rd_b;
                    if (start_max == '0)
                    begin
                        lo_zero_next = 1'b1;
                    end
                    else
                    begin
                        lo_zero_next = 1'b0;
                        mem_re       = 1'b1;
                        mem_raddr    = start_m1[AW-1:0];
                    end
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    red_next       = sat_r;
                    green_next     = sat_g;
                    blue_next      = sat_b;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_count_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            tail_r_reg    <= '0;
            tail_g_reg    <= '0;
            tail_b_reg    <= '0;
            tail_last_reg <= ONE;
        end
        else
        begin
            state_reg     <= state_next;
            op_count_reg  <= op_count_next;
            rsp_valid_reg <= rsp_valid_next;
            tail_r_reg    <= tail_r_next;
            tail_g_reg    <= tail_g_next;
            tail_b_reg    <= tail_b_next;
            tail_last_reg <= tail_last_next;
        end
    end

    // Query working values and result payload.
    always_ff @(posedge clk)
    begin
        right_reg   <= right_next;
        start_reg   <= start_next;
        hi_r_reg    <= hi_r_next;
        hi_g_reg    <= hi_g_next;
        hi_b_reg    <= hi_b_next;
        lo_zero_reg <= lo_zero_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

### sv/saturating_paint_range_query.sv
// ----------------------------------------------------------------------------
// saturating_paint_range_query
// Paint operation log with per-channel prefix sums and saturating range query.
// ----------------------------------------------------------------------------
// Clear and append requests end at acceptance; an append writes one entry
// (prefix sums plus last set index) and keeps a copy of the newest entry in
// registers, so it needs no read. A query holds the request channel through
// the right-read and finish states (only the finish state when the sequence
// is empty), and its result is loaded into the output register from the
// finish state. The query rests on two dependent reads through the single
// read port of the entry memory: the right entry gives the last set index,
// which picks the start entry. A finished result waits in an output register
// while the next request is accepted; a query that finishes while that
// register is still full waits for it to drain. Entry zero is held as a
// constant, so no clearing pass is run after reset.
module saturating_paint_range_query #(
    parameter int MAX_OPS = 1024,
    localparam int IDX_W  = $clog2(MAX_OPS + 1),
    localparam int AW     = $clog2(MAX_OPS),
    localparam int PW     = $clog2(MAX_OPS * 255 + 1),
    localparam int EW     = 3 * PW + IDX_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [1:0]       func,
    input  logic             kind,
    input  logic [7:0]       red_in,
    input  logic [7:0]       green_in,
    input  logic [7:0]       blue_in,
    input  logic [IDX_W-1:0] left_index,
    input  logic [IDX_W-1:0] right_index,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out
);

    import spq_pkg::*;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rd_data;

    // Sequencer and result register.
    spq_ctrl #(.MAX_OPS(MAX_OPS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .kind        (kind),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .left_index  (left_index),
        .right_index (right_index),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rd_data (mem_rd_data)
    );

    // Entries one through MAX_OPS live at address index minus one.
    spq_mem #(.DEPTH(MAX_OPS), .AW(AW), .EW(EW)) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rd_data (mem_rd_data)
    );

endmodule

### sim/saturating_paint_range_query_tb.sv
// ----------------------------------------------------------------------------
// saturating_paint_range_query_tb
// Self-checking testbench for the saturating paint range query.
// ----------------------------------------------------------------------------
// A clocked driver takes requests from a pending queue and presents them on
// the request channel. At each accepted transaction it updates a local paint
// log (prefix sums and last set index per entry) and, for a query, queues the
// expected color. A clocked monitor takes results from the response channel
// and compares them field by field with the oldest expected color. The
// traffic runs in three profiles of idling, includes a sequence filled to
// capacity, and applies one long output stall.
// ----------------------------------------------------------------------------
module saturating_paint_range_query_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int MAX_OPS     = 1024;
    localparam int IDX_W       = 11;
    localparam int IDX_MAX     = (1 << IDX_W) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 12;

    // Function code that the block ignores.
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic             kind;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [IDX_W-1:0] left_idx;
        logic [IDX_W-1:0] right_idx;
    } paint_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } paint_color_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    logic [1:0]       func = FN_CLEAR;
    logic             kind = 1'b0;
    logic [7:0]       red_in = '0;
    logic [7:0]       green_in = '0;
    logic [7:0]       blue_in = '0;
    logic [IDX_W-1:0] left_index = '0;
    logic [IDX_W-1:0] right_index = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;

    // Requests waiting for the driver, and colors waiting for the monitor.
    paint_req_t   pending_q[$];
    paint_color_t expected_colors[$];

    // Local paint log, indexed by operation number.
    logic [17:0]      log_red   [0:MAX_OPS];
    logic [17:0]      log_green [0:MAX_OPS];
    logic [17:0]      log_blue  [0:MAX_OPS];
    logic [IDX_W-1:0] log_last_set [0:MAX_OPS];
    int unsigned      log_len = 0;

    int errors = 0;
    int results_checked = 0;
    int n_clear = 0;
    int n_append = 0;
    int n_query = 0;
    int n_ignored = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long output stall control: the stimulus asks, the stall process serves.
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    saturating_paint_range_query #(
        .MAX_OPS(MAX_OPS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .func       (func),
        .kind       (kind),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .left_index (left_index),
        .right_index(right_index),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out)
    );

    always #5 clk = ~clk;

    // Sum of one channel between two prefix entries, clipped to one byte.
    function automatic logic [7:0] clipped_sum(input logic [17:0] hi, input logic [17:0] lo);
        logic [17:0] diff;
        diff = (hi >= lo) ? hi - lo : 18'd0;
        return (diff > CHAN_SAT) ? CHAN_SAT : diff[7:0];
    endfunction

    // Applies one accepted request to the paint log and queues its color.
    task automatic apply_paint_request(input paint_req_t r);
        int unsigned  n;
        int unsigned  hi;
        int unsigned  start;
        int unsigned  set_start;
        paint_color_t color;
        case (r.func)
            FN_CLEAR:
            begin
                n_clear++;
                log_len         = 0;
                log_last_set[0] = IDX_W'(1);
                log_red[0]      = '0;
                log_green[0]    = '0;
                log_blue[0]     = '0;
            end
            FN_APPEND:
            begin
                n_append++;
                if (log_len < MAX_OPS)
                begin
                    n               = log_len + 1;
                    log_red[n]      = log_red[n-1] + r.red;
                    log_green[n]    = log_green[n-1] + r.green;
                    log_blue[n]     = log_blue[n-1] + r.blue;
                    log_last_set[n] = r.kind ? IDX_W'(n) : log_last_set[n-1];
                    log_len         = n;
                end
            end
            FN_QUERY:
            begin
                n_query++;
                hi        = (r.right_idx > log_len) ? log_len : r.right_idx;
                start     = (r.left_idx == 0) ? 0 : r.left_idx - 1;
                set_start = log_last_set[hi] - 1;
                if (set_start > start)
                    start = set_start;
                if (start >= hi)
                    color = '0;
                else
                begin
                    color.red   = clipped_sum(log_red[hi], log_red[start]);
                    color.green = clipped_sum(log_green[hi], log_green[start]);
                    color.blue  = clipped_sum(log_blue[hi], log_blue[start]);
                end
                expected_colors.push_back(color);
            end
            default:
                n_ignored++;
        endcase
    endtask

    // Request driver: records each accepted transaction, then offers the next.
    always @(posedge clk or negedge rst_n)
    begin
        paint_req_t cur;
        paint_req_t nxt;
        if (!rst_n)
        begin
            req_valid       <= 1'b0;
            log_len         = 0;
            log_last_set[0] = IDX_W'(1);
            log_red[0]      = '0;
            log_green[0]    = '0;
            log_blue[0]     = '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                cur = '{func, kind, red_in, green_in, blue_in, left_index, right_index};
                apply_paint_request(cur);
            end
            if (!req_valid || req_ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    req_valid   <= 1'b1;
                    func        <= nxt.func;
                    kind        <= nxt.kind;
                    red_in      <= nxt.red;
                    green_in    <= nxt.green;
                    blue_in     <= nxt.blue;
                    left_index  <= nxt.left_idx;
                    right_index <= nxt.right_idx;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Long output stall, counted down in its own process.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_served != holds_asked)
        begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result monitor: checks each accepted transaction, then sets ready.
    always @(posedge clk or negedge rst_n)
    begin
        paint_color_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, red_out, green_out, blue_out);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    check_channel("red_out", want.red, red_out);
                    check_channel("green_out", want.green, green_out);
                    check_channel("blue_out", want.blue, blue_out);
                    results_checked++;
                end
            end
            if (hold_left != 0)
                rsp_ready <= 1'b0;
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int unsigned planned_len;
        int unsigned seq_target;

        planned_len = 0;
        seq_target  = 8;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Profile one: sender rarely idles, receiver mostly idles.
        @(negedge clk);
        send_idle_pct = 6;
        recv_idle_pct = 76;

        // Directed: empty log, ignored code, saturation, set points, clipping.
        push_query(11'd1, 11'd1);
        push_query(11'd0, 11'd0);
        push_req(FN_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 11'h7FF);
        push_append(1'b0, 8'd255, 8'd0, 8'd128);
        push_append(1'b0, 8'd1, 8'd255, 8'd0);
        push_append(1'b1, 8'd10, 8'd20, 8'd30);
        push_append(1'b0, 8'd5, 8'd5, 8'd5);
        push_append(1'b0, 8'd255, 8'd255, 8'd255);
        push_query(11'd1, 11'd2);
        push_query(11'd1, 11'd5);
        push_query(11'd4, 11'd5);
        push_query(11'd1, 11'd4);
        push_query(11'd0, 11'h7FF);
        push_query(11'h7FF, 11'd1);
        push_query(11'd3, 11'd2);
        push_query(11'd1, 11'd1);
        push_query(11'd3, 11'd3);
        push_req(FN_UNUSED, 1'b0, 8'h00, 8'h00, 8'h00, 11'h000, 11'h000);
        push_req(FN_CLEAR, 1'b1, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 11'h7FF);
        push_query(11'd1, 11'd5);
        push_append(1'b1, 8'd255, 8'd255, 8'd255);
        push_query(11'd1, 11'd1);
        push_query(11'd1, 11'd2);
        push_req(FN_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00, 11'h000, 11'h000);

        planned_len = 0;
        repeat (200) push_mixed(planned_len, seq_target);

        // The sender stops until every result has been checked.
        wait_all_done();

        // Profile two: sender mostly idles, receiver rarely; fill the log.
        send_idle_pct = 76;
        recv_idle_pct = 6;
        push_req(FN_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00, 11'h000, 11'h000);
        planned_len = 0;
        for (int i = 1; i <= MAX_OPS + 4; i++)
        begin
            push_append(($urandom_range(9) == 0), rand_chan(), rand_chan(), rand_chan());
            if (planned_len < MAX_OPS)
                planned_len++;
            if (i % 25 == 0)
                push_random_query(planned_len);
        end
        push_query(11'd1, 11'h7FF);
        push_query(11'd1024, 11'd1024);
        push_query(11'd1023, 11'd1024);
        push_query(11'd0, 11'd1024);
        repeat (4) push_random_query(planned_len);
        wait_all_done();

        // Profile three: no idling, with one long output stall up front.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_req(FN_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00, 11'h000, 11'h000);
        planned_len = 0;
        repeat (12)
        begin
            push_append(($urandom_range(3) == 0), rand_chan(), rand_chan(), rand_chan());
            planned_len++;
        end
        holds_asked++;
        repeat (40) push_random_query(planned_len);
        seq_target = 20;
        repeat (180) push_mixed(planned_len, seq_target);

        wait_all_done();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d clears, %0d appends, %0d queries and %0d ignored requests",
                 n_clear, n_append, n_query, n_ignored);
        $display("Checked %0d results over three idling profiles, a full log and a long stall",
                 results_checked);
        if (errors == 0 && expected_colors.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    task automatic push_req(input logic [1:0] f, input logic k, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b,
                            input logic [IDX_W-1:0] lft, input logic [IDX_W-1:0] rgt);
        pending_q.push_back('{f, k, r, g, b, lft, rgt});
    endtask

    // Append with random bits in the unused index fields.
    task automatic push_append(input logic k, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        push_req(FN_APPEND, k, r, g, b, IDX_W'($urandom_range(IDX_MAX)),
                 IDX_W'($urandom_range(IDX_MAX)));
    endtask

    // Query with random bits in the unused color fields.
    task automatic push_query(input logic [IDX_W-1:0] lft, input logic [IDX_W-1:0] rgt);
        push_req(FN_QUERY, 1'($urandom_range(1)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), lft, rgt);
    endtask

    // Half full-range bytes, half small ones so that sums often stay unclipped.
    function automatic logic [7:0] rand_chan();
        return $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    endfunction

    // Mostly ranges inside the log; some reversed, some over the whole index space.
    task automatic push_random_query(input int unsigned len);
        int sel;
        int rgt;
        sel = $urandom_range(99);
        if (len == 0 || sel < 12)
            push_query(IDX_W'($urandom_range(IDX_MAX)), IDX_W'($urandom_range(IDX_MAX)));
        else if (sel < 22)
        begin
            rgt = $urandom_range(len, 1);
            push_query(IDX_W'(rgt + $urandom_range(3, 1)), IDX_W'(rgt));
        end
        else
        begin
            rgt = $urandom_range(len, 1);
            push_query(IDX_W'($urandom_range(rgt, 1)), IDX_W'(rgt));
        end
    endtask

    // One random request of a short paint sequence, with some noise and early clears.
    task automatic push_mixed(inout int unsigned len, inout int unsigned target);
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            push_req(FN_UNUSED, 1'($urandom_range(1)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     IDX_W'($urandom_range(IDX_MAX)), IDX_W'($urandom_range(IDX_MAX)));
        else if (sel < 8 || len >= target)
        begin
            push_req(FN_CLEAR, 1'($urandom_range(1)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     IDX_W'($urandom_range(IDX_MAX)), IDX_W'($urandom_range(IDX_MAX)));
            len    = 0;
            target = $urandom_range(40, 1);
        end
        else if (sel < 55)
        begin
            push_append(($urandom_range(99) < 30), rand_chan(), rand_chan(), rand_chan());
            len++;
        end
        else
            push_random_query(len);
    endtask

    // Returns once every request is accepted and every result has been checked.
    task automatic wait_all_done();
        while (pending_q.size() != 0 || req_valid || expected_colors.size() != 0)
            @(negedge clk);
    endtask

endmodule

### saturating_paint_range_query.f
sv/spq_pkg.sv
sv/spq_mem.sv
sv/spq_sat.sv
sv/spq_ctrl.sv
sv/saturating_paint_range_query.sv
sim/saturating_paint_range_query_tb.sv
